[rtl/va_pkg.sv]
package va_pkg;

	// Word format of every operand and result
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// Operation codes
	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_SCALE = 3'd2;
	localparam logic [2:0] OP_DOT   = 3'd3;
	localparam logic [2:0] OP_CROSS = 3'd4;
	localparam logic [2:0] OP_MAG   = 3'd5;

	// Request transaction
	typedef struct packed {
		logic [2:0]                  req_type;
		logic signed [WORD_BITS-1:0] a_x;
		logic signed [WORD_BITS-1:0] a_y;
		logic signed [WORD_BITS-1:0] a_z;
		logic signed [WORD_BITS-1:0] b_x;
		logic signed [WORD_BITS-1:0] b_y;
		logic signed [WORD_BITS-1:0] b_z;
		logic signed [WORD_BITS-1:0] scale_k;
	} va_req_t;

	// Result transaction
	typedef struct packed {
		logic signed [WORD_BITS-1:0] res_x;
		logic signed [WORD_BITS-1:0] res_y;
		logic signed [WORD_BITS-1:0] res_z;
		logic                        overflow;
	} va_res_t;

endpackage

[rtl/va_lane.sv]
// One component lane: two products and an add/sub, then the per-lane combine
module va_lane import va_pkg::*; #(
	parameter int W = WORD_BITS,
	parameter int F = FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  en1,
	input  logic                  en2,
	input  logic [2:0]            op,
	input  logic signed [W-1:0]   a_c,
	input  logic signed [W-1:0]   b_c,
	input  logic signed [W-1:0]   m0a,
	input  logic signed [W-1:0]   m0b,
	input  logic signed [W-1:0]   m1a,
	input  logic signed [W-1:0]   m1b,
	output logic signed [2*W+1:0] lane_s2
);
	localparam int PW = 2 * W + 2;

	logic [2:0]            op_s1;
	logic signed [2*W-1:0] prod0_s1;
	logic signed [2*W-1:0] prod1_s1;
	logic signed [W:0]     addsub_s1;
	logic signed [PW-1:0]  p0_ext;
	logic signed [PW-1:0]  diff;
	logic signed [PW-1:0]  lane_d;

	// Stage 1: multipliers and the componentwise add/sub
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1    <= op;
			prod0_s1 <= m0a * m0b;
			prod1_s1 <= m1a * m1b;
			if (op == OP_SUB) begin
				addsub_s1 <= {a_c[W-1], a_c} - {b_c[W-1], b_c};
			end else begin
				addsub_s1 <= {a_c[W-1], a_c} + {b_c[W-1], b_c};
			end
		end
	end

	// Stage 2: scale back products; dot and magnitude keep the exact product
	assign p0_ext = PW'(prod0_s1);
	assign diff   = p0_ext - PW'(prod1_s1);

	always_comb begin
		case (op_s1)
			OP_ADD, OP_SUB: lane_d = PW'(addsub_s1);
			OP_SCALE:       lane_d = p0_ext >>> F;
			OP_CROSS:       lane_d = diff >>> F;
			default:        lane_d = p0_ext;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			lane_s2 <= lane_d;
		end
	end

endmodule

[rtl/va_merge.sv]
// Merge stage: sums lanes for dot and mag, saturates all but magnitude
module va_merge import va_pkg::*; #(
	parameter int W = WORD_BITS,
	parameter int F = FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [2:0]            op_s2,
	input  logic signed [2*W+1:0] l0,
	input  logic signed [2*W+1:0] l1,
	input  logic signed [2*W+1:0] l2,
	output logic [W-1:0]          x_s3,
	output logic [W-1:0]          y_s3,
	output logic [W-1:0]          z_s3,
	output logic                  ovf_s3,
	output logic [2*W-1:0]        rad_s3,
	output logic                  mag_s3
);
	localparam int PW = 2 * W + 2;

	logic signed [PW-1:0] sum;
	logic [W:0]           sx;
	logic [W:0]           sy;
	logic [W:0]           sz;
	logic [W:0]           sd;

	// {overflow, value} saturated to the signed word range
	function automatic logic [W:0] sat(input logic signed [PW-1:0] v);
		logic hi_same;
		hi_same = (&v[PW-1:W-1]) | ~(|v[PW-1:W-1]);
		if (hi_same) begin
			return {1'b0, v[W-1:0]};
		end else if (v[PW-1]) begin
			return {2'b11, {(W-1){1'b0}}};
		end else begin
			return {2'b10, {(W-1){1'b1}}};
		end
	endfunction

	assign sum = l0 + l1 + l2;
	assign sx  = sat(l0);
	assign sy  = sat(l1);
	assign sz  = sat(l2);
	assign sd  = sat(sum >>> F);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= sum[2*W-1:0];
			mag_s3 <= (op_s2 == OP_MAG);
			case (op_s2)
				OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
					x_s3   <= sx[W-1:0];
					y_s3   <= sy[W-1:0];
					z_s3   <= sz[W-1:0];
					ovf_s3 <= sx[W] | sy[W] | sz[W];
				end
				OP_DOT: begin
					x_s3   <= sd[W-1:0];
					y_s3   <= '0;
					z_s3   <= '0;
					ovf_s3 <= sd[W];
				end
				default: begin
					x_s3   <= '0;
					y_s3   <= '0;
					z_s3   <= '0;
					ovf_s3 <= 1'b0;
				end
			endcase
		end
	end

endmodule

[rtl/va_sqrt.sv]
// Pipelined integer square root, one root bit per stage, side data alongside
module va_sqrt import va_pkg::*; #(
	parameter int W      = WORD_BITS,
	parameter int SIDE_W = 3 * WORD_BITS + 2
) (
	input  logic              clk,
	input  logic [W-1:0]      en,
	input  logic [2*W-1:0]    rad,
	input  logic [SIDE_W-1:0] side_in,
	output logic [W-1:0]      root,
	output logic [SIDE_W-1:0] side_out
);
	localparam int RW = 2 * W + 1;

	logic [RW-1:0]     rem_st  [0:W];
	logic [W-1:0]      root_st [0:W];
	logic [SIDE_W-1:0] side_st [0:W];

	assign rem_st[0]  = RW'(rad);
	assign root_st[0] = '0;
	assign side_st[0] = side_in;

	// Restoring method: try the next bit, keep it if the remainder allows
	for (genvar j = 0; j < W; j++) begin : g_stage
		localparam int B = W - 1 - j;
		logic [RW-1:0] trial;
		assign trial = (RW'(root_st[j]) << (B + 1)) + (RW'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (en[j]) begin
				side_st[j+1] <= side_st[j];
				if (rem_st[j] >= trial) begin
					rem_st[j+1]  <= rem_st[j] - trial;
					root_st[j+1] <= root_st[j] | (W'(1) << B);
				end else begin
					rem_st[j+1]  <= rem_st[j];
					root_st[j+1] <= root_st[j];
				end
			end
		end
	end

	assign root     = root_st[W];
	assign side_out = side_st[W];

endmodule

[rtl/vector3_arith_unit.sv]
// Three-component vector unit in signed fixed point (add, sub, scale, dot,
// cross, magnitude).
// Channels: in_valid/in_ready carry a request transaction (op code, vectors
// a and b, scalar k); out_valid/out_ready carry the result transaction
// (res_x/res_y/res_z plus overflow). Scalar results sit in res_x.
// Throughput: one transaction per cycle in each direction while out_ready is held high.
// Pipeline: the lane stages, the merge stage, the square root, which
// resolves one root bit per stage, and the output register; every
// operation travels the same pipeline so order is kept.
// Stall: every stage has its own valid bit and advances when the stage
// after it is empty or moving, so a result waiting at the output leaves
// in_ready high as long as any bubble remains upstream.
// Reset: arst_n clears all valid bits; the pipeline comes up empty and
// in_ready is high after reset.
module vector3_arith_unit import va_pkg::*; #(
	parameter int FRAC = FRAC_BITS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  va_req_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output va_res_t out_data
);
	localparam int W      = WORD_BITS;
	localparam int PW     = 2 * W + 2;
	localparam int SIDE_W = 3 * W + 2;
	localparam int N      = W + 4;

	logic [N-1:0] v_q;
	logic [N-1:0] en;

	logic signed [W-1:0] a [3];
	logic signed [W-1:0] b [3];
	logic signed [W-1:0] m0a [3];
	logic signed [W-1:0] m0b [3];
	logic signed [W-1:0] m1a [3];
	logic signed [W-1:0] m1b [3];
	logic signed [PW-1:0] lane_s2 [3];

	logic [2:0]        op_s1;
	logic [2:0]        op_s2;
	logic [W-1:0]      x_s3;
	logic [W-1:0]      y_s3;
	logic [W-1:0]      z_s3;
	logic              ovf_s3;
	logic [2*W-1:0]    rad_s3;
	logic              mag_s3;
	logic [W-1:0]      root;
	logic [SIDE_W-1:0] side_out;
	logic              mag_q;

	// Stage advance: a stage moves when it is empty or the next one moves
	always_comb begin
		en[N-1] = ~v_q[N-1] | out_ready;
		for (int i = N - 2; i >= 0; i--) begin
			en[i] = ~v_q[i] | en[i+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[N-1];

	// Valid bits per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int i = 1; i < N; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	// Operand steering into the lanes
	assign a[0] = in_data.a_x;
	assign a[1] = in_data.a_y;
	assign a[2] = in_data.a_z;
	assign b[0] = in_data.b_x;
	assign b[1] = in_data.b_y;
	assign b[2] = in_data.b_z;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int I1 = (i + 1) % 3;
		localparam int I2 = (i + 2) % 3;

		always_comb begin
			m1a[i] = '0;
			m1b[i] = '0;
			case (in_data.req_type)
				OP_SCALE: begin
					m0a[i] = a[i];
					m0b[i] = in_data.scale_k;
				end
				OP_DOT: begin
					m0a[i] = a[i];
					m0b[i] = b[i];
				end
				OP_MAG: begin
					m0a[i] = a[i];
					m0b[i] = a[i];
				end
				OP_CROSS: begin
					m0a[i] = a[I1];
					m0b[i] = b[I2];
					m1a[i] = a[I2];
					m1b[i] = b[I1];
				end
				default: begin
					m0a[i] = '0;
					m0b[i] = '0;
				end
			endcase
		end

		va_lane #(.W(W), .F(FRAC)) u_lane (
			.clk     (clk),
			.en1     (en[0]),
			.en2     (en[1]),
			.op      (in_data.req_type),
			.a_c     (a[i]),
			.b_c     (b[i]),
			.m0a     (m0a[i]),
			.m0b     (m0b[i]),
			.m1a     (m1a[i]),
			.m1b     (m1b[i]),
			.lane_s2 (lane_s2[i])
		);
	end

	// Op code follows the lanes to the merge stage
	always_ff @(posedge clk) begin
		if (en[0]) begin
			op_s1 <= in_data.req_type;
		end
		if (en[1]) begin
			op_s2 <= op_s1;
		end
	end

	va_merge #(.W(W), .F(FRAC)) u_merge (
		.clk    (clk),
		.en     (en[2]),
		.op_s2  (op_s2),
		.l0     (lane_s2[0]),
		.l1     (lane_s2[1]),
		.l2     (lane_s2[2]),
		.x_s3   (x_s3),
		.y_s3   (y_s3),
		.z_s3   (z_s3),
		.ovf_s3 (ovf_s3),
		.rad_s3 (rad_s3),
		.mag_s3 (mag_s3)
	);

	va_sqrt #(.W(W), .SIDE_W(SIDE_W)) u_sqrt (
		.clk      (clk),
		.en       (en[3 +: W]),
		.rad      (rad_s3),
		.side_in  ({mag_s3, ovf_s3, x_s3, y_s3, z_s3}),
		.root     (root),
		.side_out (side_out)
	);

	// Output register: magnitude takes the root, saturated at the top bit
	always_ff @(posedge clk) begin
		if (en[N-1]) begin
			mag_q <= side_out[SIDE_W-1];
			if (side_out[SIDE_W-1]) begin
				out_data.res_x    <= root[W-1] ? {1'b0, {(W-1){1'b1}}} : root;
				out_data.res_y    <= '0;
				out_data.res_z    <= '0;
				out_data.overflow <= root[W-1];
			end else begin
				out_data.overflow <= side_out[SIDE_W-2];
				out_data.res_x    <= side_out[3*W-1:2*W];
				out_data.res_y    <= side_out[2*W-1:W];
				out_data.res_z    <= side_out[W-1:0];
			end
		end
	end

`ifndef SYNTHESIS
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_q[N-1] |-> in_ready)
		else $error("in_ready low with an empty output stage");

	a_mag_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && mag_q) |-> !out_data.res_x[W-1])
		else $error("negative magnitude result");

	a_mag_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && mag_q) |-> (out_data.res_y == '0 && out_data.res_z == '0))
		else $error("magnitude result has nonzero y or z");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import va_pkg::*;

	localparam int LATENCY = WORD_BITS + 4;
	localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [2:0] OP_BAD6 = 3'd6;
	localparam logic [2:0] OP_BAD7 = 3'd7;

	typedef logic signed [127:0] wide_t;

	// Clip an exact value to the word range, flagging saturation
	function automatic logic signed [WORD_BITS-1:0] clip(input wide_t v, inout logic ovf);
		if (v > wide_t'(WMAX)) begin
			ovf = 1'b1;
			return WMAX;
		end
		if (v < wide_t'(WMIN)) begin
			ovf = 1'b1;
			return WMIN;
		end
		return v[WORD_BITS-1:0];
	endfunction

	function automatic wide_t mul(input logic signed [WORD_BITS-1:0] x,
			input logic signed [WORD_BITS-1:0] y);
		wide_t wx, wy;
		wx = x;
		wy = y;
		return wx * wy;
	endfunction

	// Bitwise floor square root of a non-negative wide value
	function automatic logic [63:0] floor_root(input wide_t s);
		logic [63:0] r, c;
		wide_t cc;
		r = '0;
		for (int b = 52; b >= 0; b--) begin
			c = r | (64'd1 << b);
			cc = $signed({64'd0, c}) * $signed({64'd0, c});
			if (cc <= s)
				r = c;
		end
		return r;
	endfunction

	// Expected result of one vector request
	function automatic va_res_t vector_result(input va_req_t q);
		va_res_t r;
		logic ovf;
		wide_t s;
		logic [63:0] rt;
		ovf = 1'b0;
		r = '0;
		case (q.req_type)
			OP_ADD: begin
				r.res_x = clip(wide_t'(q.a_x) + wide_t'(q.b_x), ovf);
				r.res_y = clip(wide_t'(q.a_y) + wide_t'(q.b_y), ovf);
				r.res_z = clip(wide_t'(q.a_z) + wide_t'(q.b_z), ovf);
			end
			OP_SUB: begin
				r.res_x = clip(wide_t'(q.a_x) - wide_t'(q.b_x), ovf);
				r.res_y = clip(wide_t'(q.a_y) - wide_t'(q.b_y), ovf);
				r.res_z = clip(wide_t'(q.a_z) - wide_t'(q.b_z), ovf);
			end
			OP_SCALE: begin
				r.res_x = clip(mul(q.a_x, q.scale_k) >>> FRAC_BITS, ovf);
				r.res_y = clip(mul(q.a_y, q.scale_k) >>> FRAC_BITS, ovf);
				r.res_z = clip(mul(q.a_z, q.scale_k) >>> FRAC_BITS, ovf);
			end
			OP_DOT: begin
				s = mul(q.a_x, q.b_x) + mul(q.a_y, q.b_y) + mul(q.a_z, q.b_z);
				r.res_x = clip(s >>> FRAC_BITS, ovf);
			end
			OP_CROSS: begin
				r.res_x = clip((mul(q.a_y, q.b_z) - mul(q.a_z, q.b_y)) >>> FRAC_BITS, ovf);
				r.res_y = clip((mul(q.a_z, q.b_x) - mul(q.a_x, q.b_z)) >>> FRAC_BITS, ovf);
				r.res_z = clip((mul(q.a_x, q.b_y) - mul(q.a_y, q.b_x)) >>> FRAC_BITS, ovf);
			end
			OP_MAG: begin
				s = mul(q.a_x, q.a_x) + mul(q.a_y, q.a_y) + mul(q.a_z, q.a_z);
				rt = floor_root(s);
				if (rt > 64'(WMAX)) begin
					rt = 64'(WMAX);
					ovf = 1'b1;
				end
				r.res_x = rt[WORD_BITS-1:0];
			end
			default: ;
		endcase
		r.overflow = ovf;
		return r;
	endfunction

	class result_board;
		va_res_t pending[$];
		int errors = 0;
		int checked = 0;

		function void note_request(va_req_t q);
			pending.push_back(vector_result(q));
		endfunction

		function void check_result(va_res_t got);
			va_res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.res_x !== want.res_x)
				$display("%0t: res_x expected %h actual %h", $time, want.res_x, got.res_x);
			if (got.res_y !== want.res_y)
				$display("%0t: res_y expected %h actual %h", $time, want.res_y, got.res_y);
			if (got.res_z !== want.res_z)
				$display("%0t: res_z expected %h actual %h", $time, want.res_z, got.res_z);
			if (got.overflow !== want.overflow)
				$display("%0t: overflow expected %b actual %b", $time, want.overflow,
					got.overflow);
			if (got !== want)
				errors++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	va_req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	va_res_t out_data;

	int send_idle = 0;
	int recv_stall = 0;
	bit hold_off = 1'b0;
	int op_seen[8];
	result_board board = new();

	vector3_arith_unit dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Monitor: log accepted requests, check accepted results
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			board.note_request(in_data);
			op_seen[in_data.req_type]++;
		end
		if (arst_n && out_valid && out_ready)
			board.check_result(out_data);
	end

	// Receiver ready with random stalls and a long hold-off
	always @(posedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall);
	end

	function automatic logic signed [WORD_BITS-1:0] rand_word();
		case ($urandom_range(5))
			0: return WMAX;
			1: return WMIN;
			2: return $signed(WORD_BITS'($urandom_range(16'hffff, 0))) - (1 <<< 15);
			3: return $signed(WORD_BITS'($urandom_range(32'h7ffff))) - (1 <<< 18);
			default: return $urandom;
		endcase
	endfunction

	task automatic send(input va_req_t q);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= q;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_random(input int n);
		va_req_t q;
		for (int i = 0; i < n; i++) begin
			q.req_type = ($urandom_range(49) == 0) ? 3'($urandom_range(7, 6))
				: 3'($urandom_range(5));
			q.a_x = rand_word();
			q.a_y = rand_word();
			q.a_z = rand_word();
			q.b_x = rand_word();
			q.b_y = rand_word();
			q.b_z = rand_word();
			q.scale_k = rand_word();
			send(q);
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic directed();
		va_req_t q;
		for (int op = 0; op < 8; op++) begin
			q = '{3'(op), WMAX, WMIN, WORD_BITS'(1 <<< FRAC_BITS), WMAX, WMAX, WMIN, WMIN};
			send(q);
			q = '{3'(op), WMIN, WMIN, WMIN, WMIN, WMAX, -1, -1};
			send(q);
			q = '{3'(op), WORD_BITS'(3 <<< FRAC_BITS), -WORD_BITS'(2 <<< FRAC_BITS), 1,
				-1, WORD_BITS'(5 <<< 15), 0, WORD_BITS'(1 <<< FRAC_BITS)};
			send(q);
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		drain();
		send_idle = 0;
		recv_stall = 0;
		send_random(250);
		send_idle = 78;
		recv_stall = 0;
		send_random(200);
		send_idle = 0;
		recv_stall = 78;
		send_random(250);
		send_idle = 9;
		recv_stall = 9;
		send_random(250);
		// back-pressure: fill the pipeline while the output is held
		send_idle = 0;
		recv_stall = 0;
		hold_off = 1'b1;
		send_random(100);
		send_random(150);
		drain();
		$display("Checked %0d results; ops add..mag: %0d %0d %0d %0d %0d %0d, unknown: %0d",
			board.checked, op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_SCALE],
			op_seen[OP_DOT], op_seen[OP_CROSS], op_seen[OP_MAG],
			op_seen[OP_BAD6] + op_seen[OP_BAD7]);
		$display("Phases: full rate, sparse input, stalled output, mixed, long output hold.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Long receiver hold-off, counted here while the sender keeps offering
	initial begin
		wait (hold_off);
		repeat (200) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#200000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/va_pkg.sv
rtl/va_lane.sv
rtl/va_merge.sv
rtl/va_sqrt.sv
rtl/vector3_arith_unit.sv
tb/testbench.sv
